// ===== hdl/aqpr_pkg.sv =====
// Shared types and constants for the linear array queue with prefix reversal.
// No dependencies; used by every module of the block except aqpr_ram.
package aqpr_pkg;

   localparam int unsigned DEPTH_DEFAULT = 64;
   localparam int unsigned WORD_W        = 32;
   localparam int unsigned COUNT_W       = 7;
   localparam int unsigned SIZE_W        = 7;

   localparam logic [SIZE_W-1:0] QUEUE_SIZE_RESET = 7'd64;

   // Action codes
   localparam logic [1:0] ACT_ENQ = 2'd0;
   localparam logic [1:0] ACT_DEQ = 2'd1;
   localparam logic [1:0] ACT_REV = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic [WORD_W-1:0] EMPTY_DATA = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]                action;
      logic signed [WORD_W-1:0]  value;
      logic [COUNT_W-1:0]        count;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]  data;
      logic [1:0]                status;
   } rsp_type;

   typedef enum logic [2:0] {
      RSP_NONE  = 3'd0,
      RSP_OK    = 3'd1,
      RSP_FULL  = 3'd2,
      RSP_EMPTY = 3'd3,
      RSP_DEQ   = 3'd4
   } rsp_kind_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic         enq_write;
      logic         deq_read;
      logic         deq_finish;
      logic         rev_load;
      logic         rd_lo;
      logic         rd_hi;
      logic         wr_lo;
      logic         wr_hi;
      rsp_kind_type rsp_kind;
   } cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic full;
      logic empty;
      logic swap_more;
   } stat_type;

endpackage

// ===== hdl/aqpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aqpr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/aqpr_ctrl.sv =====
// Sequencing state machine for the queue: picks the action, steps the swap loop.
// Depends on aqpr_pkg.
module aqpr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          action,
   input  aqpr_pkg::stat_type  stat,
   output aqpr_pkg::cmd_type   cmd,
   output logic                busy
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DEQ   = 6'b000010,
      ST_CHK   = 6'b000100,
      ST_RD_HI = 6'b001000,
      ST_WR_LO = 6'b010000,
      ST_WR_HI = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.rsp_kind = aqpr_pkg::RSP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               priority if (action == aqpr_pkg::ACT_ENQ) begin
                  if (stat.full) begin
                     cmd.rsp_kind = aqpr_pkg::RSP_FULL;
                  end else begin
                     cmd.enq_write = 1'b1;
                     cmd.rsp_kind  = aqpr_pkg::RSP_OK;
                  end
               end else if (action == aqpr_pkg::ACT_DEQ) begin
                  if (stat.empty) begin
                     cmd.rsp_kind = aqpr_pkg::RSP_EMPTY;
                  end else begin
                     cmd.deq_read = 1'b1;
                     state_in     = ST_DEQ;
                  end
               end else if (action == aqpr_pkg::ACT_REV) begin
                  cmd.rev_load = 1'b1;
                  state_in     = ST_CHK;
               end else begin
                  cmd.rsp_kind = aqpr_pkg::RSP_OK;
               end
            end
         end
         ST_DEQ: begin
            cmd.deq_finish = 1'b1;
            cmd.rsp_kind   = aqpr_pkg::RSP_DEQ;
            state_in       = ST_IDLE;
         end
         ST_CHK: begin
            if (stat.swap_more) begin
               cmd.rd_lo = 1'b1;
               state_in  = ST_RD_HI;
            end else begin
               cmd.rsp_kind = aqpr_pkg::RSP_OK;
               state_in     = ST_IDLE;
            end
         end
         ST_RD_HI: begin
            cmd.rd_hi = 1'b1;
            state_in  = ST_WR_LO;
         end
         ST_WR_LO: begin
            cmd.wr_lo = 1'b1;
            state_in  = ST_WR_HI;
         end
         ST_WR_HI: begin
            cmd.wr_hi = 1'b1;
            state_in  = ST_CHK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hdl/aqpr_dpath.sv =====
// Queue datapath: head/tail counters, swap pointers, slot RAM, size register, result register.
// Depends on aqpr_pkg and aqpr_ram.
module aqpr_dpath #(
   parameter int unsigned DEPTH = aqpr_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  aqpr_pkg::req_type                   req,
   input  aqpr_pkg::cmd_type                   cmd,
   output aqpr_pkg::stat_type                  stat,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [aqpr_pkg::SIZE_W-1:0]         csr_data,
   output logic                                rsp_strobe,
   output aqpr_pkg::rsp_type                   rsp
);

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned W  = (CW > aqpr_pkg::COUNT_W) ? CW : aqpr_pkg::COUNT_W;

   logic [aqpr_pkg::SIZE_W-1:0] queue_size_ff;
   logic [CW-1:0]               written_ff, written_in;
   logic [CW-1:0]               taken_ff, taken_in;
   logic [CW-1:0]               lo_ff, lo_in;
   logic [CW-1:0]               hi_ff, hi_in;
   logic [aqpr_pkg::WORD_W-1:0] tmp_ff;
   logic                        rsp_strobe_ff;
   aqpr_pkg::rsp_type           rsp_ff, rsp_in;

   logic [CW-1:0]               occ;
   logic [CW-1:0]               rev_k;
   logic                        ram_wr_en, ram_rd_en;
   logic [AW-1:0]               ram_wr_addr, ram_rd_addr;
   logic [aqpr_pkg::WORD_W-1:0] ram_wr_data, ram_rd_data;

   assign csr_ready = 1'b1;

   // Status flags; min(size, DEPTH) folds into two compares
   assign stat.full  = (W'(written_ff) >= W'(queue_size_ff)) || (written_ff >= CW'(DEPTH));
   assign stat.empty = (taken_ff >= written_ff);
   assign stat.swap_more = ((CW + 1)'(hi_ff) > ((CW + 1)'(lo_ff) + (CW + 1)'(1)));

   assign occ   = written_ff - taken_ff;
   assign rev_k = (W'(req.count) > W'(occ)) ? occ : CW'(req.count);

   // Memory port steering
   always_comb begin
      ram_wr_en   = cmd.enq_write | cmd.wr_lo | cmd.wr_hi;
      ram_wr_addr = written_ff[AW-1:0];
      ram_wr_data = req.value;
      if (cmd.wr_lo) begin
         ram_wr_addr = lo_ff[AW-1:0];
         ram_wr_data = ram_rd_data;
      end else if (cmd.wr_hi) begin
         ram_wr_addr = hi_ff[AW-1:0];
         ram_wr_data = tmp_ff;
      end
      ram_rd_en   = cmd.deq_read | cmd.rd_lo | cmd.rd_hi;
      ram_rd_addr = taken_ff[AW-1:0];
      if (cmd.rd_lo) begin
         ram_rd_addr = lo_ff[AW-1:0];
      end else if (cmd.rd_hi) begin
         ram_rd_addr = hi_ff[AW-1:0];
      end
   end

   aqpr_ram #(
      .WIDTH (aqpr_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Counters and swap pointers
   always_comb begin
      written_in = written_ff;
      taken_in   = taken_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      if (cmd.enq_write) begin
         written_in = written_ff + CW'(1);
      end
      if (cmd.deq_finish) begin
         taken_in = taken_ff + CW'(1);
      end
      if (cmd.rev_load) begin
         lo_in = taken_ff;
         hi_in = taken_ff + rev_k;
      end
      if (cmd.rd_lo) begin
         hi_in = hi_ff - CW'(1);
      end
      if (cmd.wr_hi) begin
         lo_in = lo_ff + CW'(1);
      end
   end

   // Result beat
   always_comb begin
      rsp_in.data   = '0;
      rsp_in.status = aqpr_pkg::ST_OK;
      unique case (cmd.rsp_kind)
         aqpr_pkg::RSP_FULL: begin
            rsp_in.status = aqpr_pkg::ST_FULL;
         end
         aqpr_pkg::RSP_EMPTY: begin
            rsp_in.data   = aqpr_pkg::EMPTY_DATA;
            rsp_in.status = aqpr_pkg::ST_EMPTY;
         end
         aqpr_pkg::RSP_DEQ: begin
            rsp_in.data = ram_rd_data;
         end
         default: begin
            rsp_in.status = aqpr_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_size_ff <= aqpr_pkg::QUEUE_SIZE_RESET;
         written_ff    <= '0;
         taken_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            queue_size_ff <= csr_data;
         end
         written_ff    <= written_in;
         taken_ff      <= taken_in;
         rsp_strobe_ff <= (cmd.rsp_kind != aqpr_pkg::RSP_NONE);
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      rsp_ff <= rsp_in;
      if (cmd.rd_hi) begin
         tmp_ff <= ram_rd_data;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

// ===== hdl/array_queue_with_prefix_reverse.sv =====
// Enqueue: result is registered from the accept cycle; next item may start the following cycle.
// Dequeue: one slot RAM read, then ST_DEQ registers the result; busy while in ST_DEQ.
// Reverse: floor(k/2) swaps through ST_CHK, ST_RD_HI, ST_WR_LO, ST_WR_HI, k = count saturated to occupancy;
//   each swap is two reads and two writes through the single-port-pair slot RAM.
// Reset clears head, tail and result strobe and sets queue_size to 64; slot RAM is not cleared.
// Results are single-cycle strobed beats; the receiver cannot stall.
module array_queue_with_prefix_reverse #(
   parameter int unsigned DEPTH = aqpr_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         start,
   output logic                         busy,
   input  aqpr_pkg::req_type            req_payload,
   // result channel
   output logic                         rsp_strobe,
   output aqpr_pkg::rsp_type            rsp_payload,
   // queue_size register write
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [aqpr_pkg::SIZE_W-1:0]  csr_data
);

   aqpr_pkg::cmd_type  cmd;
   aqpr_pkg::stat_type stat;

   // Sequencer: decodes the accepted beat and walks the swap loop
   aqpr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_payload.action),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Storage, pointers and result register
   aqpr_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req        (req_payload),
      .cmd        (cmd),
      .stat       (stat),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_payload)
   );

endmodule
